@@ src/hrlp_pkg.sv @@
package hrlp_pkg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] section;
        logic       line_done;
        logic [2:0] verdict;
    } t_result;

endpackage

@@ src/hrlp_result_fifo.sv @@
module hrlp_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_count,
    input  hrlp_pkg::t_result i_push_data [2],
    output logic              o_room,
    output logic              o_valid,
    output hrlp_pkg::t_result o_data,
    input  logic              i_ready
);
    import hrlp_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW:0]     r_count;
    logic [AW-1:0]   wr_ptr_next_slot;
    logic            pop;

    assign pop              = (r_count != '0) && i_ready;
    assign wr_ptr_next_slot = r_wr_ptr + AW'(1);
    assign o_valid          = (r_count != '0);
    assign o_data           = r_mem[r_rd_ptr];
    assign o_room           = (r_count <= (AW+1)'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(i_push_count);
            r_rd_ptr <= r_rd_ptr + AW'(pop);
            r_count  <= r_count + (AW+1)'(i_push_count) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push_data[0];
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_ptr_next_slot] <= i_push_data[1];
        end
    end

endmodule

@@ src/http_request_line_parser.sv @@
// HTTP request start-line parser.
// The slave stream takes one character of the start line per request in
// s_axis_tdata, with s_axis_tlast marking the final character of the line.
// The master stream returns field characters tagged with their section in
// m_axis_tuser order (byte_valid, then section), and after the final
// character a verdict result with m_axis_tlast set and the first error code
// in m_axis_tdata[10:8].
// One input character gives zero, one or two results. A character is parsed
// in the cycle it is accepted and its results are written into a
// four-entry result queue, whose head drives the master stream.
// A character can be accepted every cycle while at least two queue entries
// are free; sustained throughput is one character per cycle when each gives
// one result, and the master side's rate of one result per cycle bounds it.
// When the receiver stalls, the queue fills and s_axis_tready falls once
// fewer than two entries are free; nothing is lost or repeated.
// Synchronous reset empties the queue and returns the parser to the start of
// a line; the parser also returns there after every final character.
module http_request_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] verdict
    output logic [2:0]  m_axis_tuser,   // [0] byte_valid, [2:1] section
    output logic        m_axis_tlast
);
    import hrlp_pkg::*;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUERY   = 8'h3F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd1;
    localparam logic [2:0] ERR_SHORT_ESC = 3'd2;
    localparam logic [2:0] ERR_NO_SLASH  = 3'd3;
    localparam logic [2:0] ERR_VERSION   = 3'd4;
    localparam logic [2:0] ERR_EXTRA     = 3'd5;
    localparam logic [2:0] ERR_COUNT     = 3'd6;
    localparam logic [2:0] ERR_METHOD    = 3'd7;

    localparam logic [1:0] FLD_METHOD  = 2'd0;
    localparam logic [1:0] FLD_TARGET  = 2'd1;
    localparam logic [1:0] FLD_VERSION = 2'd2;
    localparam logic [1:0] FLD_EXTRA   = 2'd3;

    localparam logic [1:0] SEC_METHOD  = 2'd0;
    localparam logic [1:0] SEC_TARGET  = 2'd1;
    localparam logic [1:0] SEC_QUERY   = 2'd2;
    localparam logic [1:0] SEC_VERSION = 2'd3;

    localparam logic [1:0] URI_TARGET   = 2'd0;
    localparam logic [1:0] URI_QUERY    = 2'd1;
    localparam logic [1:0] URI_FRAGMENT = 2'd2;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_FIRST = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    localparam logic [3:0] VERSION_LEN     = 4'd8;
    localparam logic [3:0] VERSION_LAST    = 4'd7;
    localparam logic [3:0] VERSION_POS_MAX = 4'd15;
    localparam logic [2:0] COUNT_MAX       = 3'd7;
    localparam logic [2:0] FIELDS_EXPECTED = 3'd3;

    typedef struct packed {
        logic [1:0] field_index;
        logic       field_has_bytes;
        logic [2:0] field_count;
        logic [1:0] uri_part;
        logic [1:0] escape_phase;
        logic [7:0] escape_first_char;
        logic [3:0] version_position;
        logic       version_mismatch;
        logic [2:0] first_error;
    } t_state;

    typedef struct packed {
        t_state     st;
        logic       emit;
        logic [7:0] ch;
        logic [1:0] sec;
    } t_step;

    function automatic logic [2:0] keep_first(logic [2:0] cur, logic [2:0] code);
        return (cur == ERR_OK) ? code : cur;
    endfunction

    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

    function automatic logic [7:0] version_char(logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0: ch = 8'h48;
            3'd1: ch = 8'h54;
            3'd2: ch = 8'h54;
            3'd3: ch = 8'h50;
            3'd4: ch = 8'h2F;
            3'd5: ch = 8'h31;
            3'd6: ch = 8'h2E;
            default: ch = 8'h31;
        endcase
        return ch;
    endfunction

    function automatic t_step end_target(t_state s);
        t_step r;
        r = '0;
        r.st = s;
        if (s.escape_phase != ESC_NONE) begin
            r.st.first_error = keep_first(s.first_error, ERR_SHORT_ESC);
            if (s.escape_phase == ESC_SECOND && s.escape_first_char != CH_PERCENT) begin
                r.emit = 1'b1;
                r.ch   = s.escape_first_char;
                r.sec  = SEC_TARGET;
            end
        end
        r.st.escape_phase = ESC_NONE;
        return r;
    endfunction

    function automatic t_step close_field(t_state s);
        t_step r;
        r = '0;
        r.st = s;
        if (s.field_index == FLD_TARGET) begin
            if (!s.field_has_bytes) begin
                r.st.first_error = keep_first(r.st.first_error, ERR_NO_SLASH);
            end
            if (s.uri_part == URI_TARGET) begin
                r = end_target(r.st);
            end
        end else if (s.field_index == FLD_VERSION) begin
            if (s.version_position != VERSION_LEN || s.version_mismatch) begin
                r.st.first_error = keep_first(r.st.first_error, ERR_VERSION);
            end
        end else if (s.field_index == FLD_EXTRA) begin
            r.st.first_error = keep_first(r.st.first_error, ERR_EXTRA);
        end
        if (s.field_count < COUNT_MAX) begin
            r.st.field_count = s.field_count + 3'd1;
        end
        if (s.field_index < FLD_EXTRA) begin
            r.st.field_index = s.field_index + 2'd1;
        end
        r.st.field_has_bytes   = 1'b0;
        r.st.uri_part          = URI_TARGET;
        r.st.escape_phase      = ESC_NONE;
        r.st.escape_first_char = 8'd0;
        r.st.version_position  = 4'd0;
        r.st.version_mismatch  = 1'b0;
        return r;
    endfunction

    function automatic t_step field_byte(t_state s, logic [7:0] c);
        t_step      r;
        logic [4:0] hi;
        logic [4:0] lo;
        r  = '0;
        r.st = s;
        hi = hex_value(s.escape_first_char);
        lo = hex_value(c);
        unique case (s.field_index)
            FLD_METHOD: begin
                if (c < CH_UPPER_A || c > CH_UPPER_Z) begin
                    r.st.first_error = keep_first(r.st.first_error, ERR_METHOD);
                end
                r.emit = 1'b1;
                r.ch   = c;
                r.sec  = SEC_METHOD;
            end
            FLD_TARGET: begin
                if (!s.field_has_bytes && c != CH_SLASH) begin
                    r.st.first_error = keep_first(r.st.first_error, ERR_NO_SLASH);
                end
                if (s.uri_part == URI_TARGET) begin
                    if (c == CH_HASH) begin
                        r = end_target(r.st);
                        r.st.uri_part = URI_FRAGMENT;
                    end else if (c == CH_QUERY) begin
                        r = end_target(r.st);
                        r.st.uri_part = URI_QUERY;
                    end else if (s.escape_phase == ESC_FIRST) begin
                        r.st.escape_first_char = c;
                        r.st.escape_phase      = ESC_SECOND;
                    end else if (s.escape_phase == ESC_SECOND) begin
                        r.emit = 1'b1;
                        r.sec  = SEC_TARGET;
                        if (hi[4] || lo[4] || (hi == 5'd0 && lo == 5'd0)) begin
                            r.st.first_error = keep_first(r.st.first_error, ERR_BAD_HEX);
                            r.ch = 8'd0;
                        end else begin
                            r.ch = {hi[3:0], lo[3:0]};
                        end
                        r.st.escape_phase = ESC_NONE;
                    end else if (c == CH_PERCENT) begin
                        r.st.escape_phase = ESC_FIRST;
                    end else begin
                        r.emit = 1'b1;
                        r.ch   = c;
                        r.sec  = SEC_TARGET;
                    end
                end else if (s.uri_part == URI_QUERY) begin
                    if (c == CH_HASH) begin
                        r.st.uri_part = URI_FRAGMENT;
                    end else begin
                        r.emit = 1'b1;
                        r.ch   = c;
                        r.sec  = SEC_QUERY;
                    end
                end
            end
            FLD_VERSION: begin
                if (s.version_position >= VERSION_LEN) begin
                    r.st.version_mismatch = 1'b1;
                end else if (s.version_position == VERSION_LAST) begin
                    if (c != CH_ONE && c != CH_ZERO) begin
                        r.st.version_mismatch = 1'b1;
                    end
                end else if (c != version_char(s.version_position[2:0])) begin
                    r.st.version_mismatch = 1'b1;
                end
                if (s.version_position < VERSION_POS_MAX) begin
                    r.st.version_position = s.version_position + 4'd1;
                end
                r.emit = 1'b1;
                r.ch   = c;
                r.sec  = SEC_VERSION;
            end
            default: begin
            end
        endcase
        r.st.field_has_bytes = 1'b1;
        return r;
    endfunction

    t_state     r_state;
    t_state     n_state;
    t_state     mid_state;
    t_step      first_step;
    t_step      last_close;
    logic [7:0] in_char;
    logic       in_last;
    logic [2:0] final_error;
    t_result    res_first;
    t_result    res_close;
    t_result    res_verdict;
    t_result    push_data [2];
    logic [1:0] push_n;
    logic [1:0] push_count;
    logic       room;
    logic       accept;
    t_result    out_res;

    assign in_char = s_axis_tdata;
    assign in_last = s_axis_tlast;

    always_comb begin
        if (in_char == CH_SPACE) begin
            first_step = close_field(r_state);
        end else begin
            first_step = field_byte(r_state, in_char);
        end
        mid_state  = first_step.st;
        last_close = '0;
        last_close.st = mid_state;
        if (in_last && in_char != CH_SPACE) begin
            last_close = close_field(mid_state);
        end
        final_error = last_close.st.first_error;
        if (last_close.st.field_count != FIELDS_EXPECTED) begin
            final_error = keep_first(final_error, ERR_COUNT);
        end
        n_state = in_last ? t_state'('0) : last_close.st;

        res_first   = '{out_byte: first_step.ch, byte_valid: 1'b1, section: first_step.sec,
                        line_done: 1'b0, verdict: ERR_OK};
        res_close   = '{out_byte: last_close.ch, byte_valid: 1'b1, section: last_close.sec,
                        line_done: 1'b0, verdict: ERR_OK};
        res_verdict = '{out_byte: 8'd0, byte_valid: 1'b0, section: SEC_METHOD,
                        line_done: 1'b1, verdict: final_error};

        push_data[0] = res_verdict;
        push_data[1] = res_verdict;
        push_n       = 2'd0;
        if (first_step.emit) begin
            push_data[0] = res_first;
            push_n       = 2'd1;
            if (last_close.emit) begin
                push_data[1] = res_close;
                push_n       = 2'd2;
            end else if (in_last) begin
                push_n       = 2'd2;
            end
        end else if (last_close.emit) begin
            push_data[0] = res_close;
            push_n       = 2'd2;
        end else if (in_last) begin
            push_n       = 2'd1;
        end
    end

    assign accept        = s_axis_tvalid && room;
    assign s_axis_tready = room;
    assign push_count    = accept ? push_n : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    hrlp_result_fifo u_result_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_push_data  (push_data),
        .o_room       (room),
        .o_valid      (m_axis_tvalid),
        .o_data       (out_res),
        .i_ready      (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, out_res.verdict, out_res.out_byte};
    assign m_axis_tuser = {out_res.section, out_res.byte_valid};
    assign m_axis_tlast = out_res.line_done;

endmodule
